@@ rtl/core/rwam_pkg.sv @@
// Shared constants, types and the compare function for the rolling window arg-extreme block.
// No dependencies; used by rwam_ctrl, rwam_dp and rolling_window_argmin_argmax.
`timescale 1ns / 1ps

package rwam_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SAMPLE_W   = 32;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIND_MAX      = 2'd2;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [ADDR_W-1:0] k;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             active;
  } sts_t;

  // True when cand beats best; strict, so ties keep the earlier sample.
  function automatic logic better(input logic signed [SAMPLE_W-1:0] cand,
                                  input logic signed [SAMPLE_W-1:0] best,
                                  input logic                       fmax);
    better = fmax ? (cand > best) : (cand < best);
  endfunction

endpackage

@@ rtl/core/rolling_window_argmin_argmax.sv @@
// Top level of the rolling window arg-extreme block: config registers, controller and datapath.
// Depends on rwam_pkg, rwam_ctrl and rwam_dp.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid / in_stall | in_sample[31:0], in_series_start
//   out     | output    | out_valid/out_stall | out_position[5:0]
//   cfg     | input     | cfg_we              | cfg_index[1:0], cfg_wdata[5:0]
//
// A transaction steps through accept, n registered ring reads (n being the ring entries
// searched, 0..32), a drain of the last read and compare, and a register of the result.
// Reset is synchronous, active low; it clears pointers, sample count and handshake state.
// A finished result waits in the output register while the next transaction is accepted;
// a stalled result holds the block only at the end of the following scan.
`timescale 1ns / 1ps

module rolling_window_argmin_argmax (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rwam_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_series_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rwam_pkg::CFG_W-1:0]           out_position,
  input  logic                                 cfg_we,
  input  logic [rwam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rwam_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [rwam_pkg::CFG_W-1:0] win_len_r;
  logic                       partial_r;
  logic                       find_max_r;
  rwam_pkg::cmd_t             cmd;
  rwam_pkg::sts_t             sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r  <= rwam_pkg::WIN_RESET;
      partial_r  <= 1'b1;
      find_max_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwam_pkg::REG_WINDOW_LENGTH: win_len_r  <= cfg_wdata;
        rwam_pkg::REG_PARTIAL_MODE:  partial_r  <= cfg_wdata[0];
        rwam_pkg::REG_FIND_MAX:      find_max_r <= cfg_wdata[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  rwam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwam_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .in_series_start (in_series_start),
    .win_len         (win_len_r),
    .partial_mode    (partial_r),
    .find_max        (find_max_r),
    .cmd             (cmd),
    .sts             (sts),
    .out_position    (out_position)
  );

endmodule

@@ rtl/core/rwam_ctrl.sv @@
// Controller for the rolling window arg-extreme block: accept, scan sequencing, output handshake.
// Depends on rwam_pkg.
`timescale 1ns / 1ps

module rwam_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  rwam_pkg::sts_t  sts,
  output rwam_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE  = 3'b001,
    SCAN  = 3'b010,
    FINAL = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [rwam_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;
  logic                       issue;
  logic                       finish;

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == IDLE);
  assign issue     = (state_r == SCAN) && sts.active && (cnt_r < sts.n);
  assign finish    = (state_r == FINAL) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd.load   = accept;
    cmd.issue  = issue;
    cmd.k      = cnt_r[rwam_pkg::ADDR_W-1:0];
    cmd.finish = finish;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = issue;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = SCAN;
        end
      end
      SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = FINAL;
        end
      end
      FINAL: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == SCAN))
    else $error("accepted transaction did not start a scan");

  a_no_overissue: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (cnt_r < rwam_pkg::CNT_W'(rwam_pkg::MAX_WINDOW)))
    else $error("scan read issued past the ring depth");

endmodule

@@ rtl/core/rwam_dp.sv @@
// Datapath for the rolling window arg-extreme block: history ring, pointers, running best.
// Depends on rwam_pkg.
`timescale 1ns / 1ps

module rwam_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [rwam_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_series_start,
  input  logic [rwam_pkg::CFG_W-1:0]         win_len,
  input  logic                               partial_mode,
  input  logic                               find_max,
  input  rwam_pkg::cmd_t                     cmd,
  output rwam_pkg::sts_t                     sts,
  output logic [rwam_pkg::CFG_W-1:0]         out_position
);

  logic signed [rwam_pkg::SAMPLE_W-1:0] ring [rwam_pkg::MAX_WINDOW];

  logic [rwam_pkg::ADDR_W-1:0]          wp_r;
  logic [rwam_pkg::CNT_W-1:0]           seen_r;
  logic signed [rwam_pkg::SAMPLE_W-1:0] cur_r;
  logic [rwam_pkg::CNT_W-1:0]           n_r;
  logic [rwam_pkg::ADDR_W-1:0]          start_r;
  logic                                 warm_r;
  logic                                 active_r;
  logic signed [rwam_pkg::SAMPLE_W-1:0] best_r;
  logic [rwam_pkg::CNT_W-1:0]           pos_r;
  logic signed [rwam_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [rwam_pkg::ADDR_W-1:0]          rd_k_r;
  logic                                 rd_vld_r;
  logic [rwam_pkg::CFG_W-1:0]           pos_out_r;

  logic [rwam_pkg::CNT_W-1:0] w_eff;
  logic [rwam_pkg::CNT_W-1:0] seen_eff;
  logic                       warm_nxt;
  logic [rwam_pkg::CNT_W-1:0] n_nxt;
  logic [rwam_pkg::CNT_W-1:0] fin_pos;

  // Clamp the window length to 1..MAX_WINDOW.
  always_comb begin
    if (win_len == '0) begin
      w_eff = rwam_pkg::CNT_W'(1);
    end else if (rwam_pkg::CNT_W'(win_len) > rwam_pkg::CNT_W'(rwam_pkg::MAX_WINDOW)) begin
      w_eff = rwam_pkg::CNT_W'(rwam_pkg::MAX_WINDOW);
    end else begin
      w_eff = rwam_pkg::CNT_W'(win_len);
    end
  end

  assign seen_eff = in_series_start ? '0 : seen_r;
  assign warm_nxt = seen_eff < w_eff;
  assign n_nxt    = warm_nxt ? seen_eff : w_eff;

  assign sts.n      = n_r;
  assign sts.active = active_r;

  always_comb begin
    if (!active_r) begin
      fin_pos = '0;
    end else if (warm_r && ((n_r == '0) || rwam_pkg::better(cur_r, best_r, find_max))) begin
      fin_pos = n_r + 1'b1;
    end else begin
      fin_pos = pos_r;
    end
  end

  assign out_position = pos_out_r;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= ring[start_r + cmd.k];
    end
    if (cmd.finish) begin
      ring[wp_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      seen_r   <= '0;
      rd_vld_r <= 1'b0;
      active_r <= 1'b0;
      n_r      <= '0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load) begin
        seen_r   <= seen_eff;
        n_r      <= n_nxt;
        active_r <= !warm_nxt || partial_mode;
      end
      if (cmd.finish) begin
        wp_r <= wp_r + 1'b1;
        if (seen_r < rwam_pkg::CNT_W'(rwam_pkg::MAX_WINDOW)) begin
          seen_r <= seen_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r   <= in_sample;
      warm_r  <= warm_nxt;
      start_r <= wp_r - n_nxt[rwam_pkg::ADDR_W-1:0];
      pos_r   <= '0;
    end
    rd_k_r <= cmd.k;
    // Strict compare keeps the oldest of equal samples.
    if (rd_vld_r && ((rd_k_r == '0) || rwam_pkg::better(rd_data_r, best_r, find_max))) begin
      best_r <= rd_data_r;
      pos_r  <= rwam_pkg::CNT_W'(rd_k_r) + 1'b1;
    end
    if (cmd.finish) begin
      pos_out_r <= rwam_pkg::CFG_W'(fin_pos);
    end
  end

  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= rwam_pkg::CNT_W'(rwam_pkg::MAX_WINDOW))
    else $error("sample count above ring depth");

  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (rwam_pkg::CNT_W'(rd_k_r) < n_r))
    else $error("ring read outside the window");

endmodule

@@ bench/tb_rolling_window_argmin_argmax.sv @@
// Self-checking testbench for rolling_window_argmin_argmax: directed rows, then random series.
// Depends on rwam_pkg and the RTL top level; predicts each position with a local window model.
`timescale 1ns / 1ps

module tb_rolling_window_argmin_argmax;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int DIR_ROWS     = 30;
  localparam int MAX_REPORTS  = 10;

  // Index past the register list; writes to it must be dropped.
  localparam logic [rwam_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [rwam_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [rwam_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {RUN_RANDOM, RUN_TIES, RUN_EXTREMES, RUN_RISING, RUN_FALLING} run_kind_t;

  typedef struct packed {
    row_kind_t                            kind;
    logic signed [rwam_pkg::SAMPLE_W-1:0] smp;
    logic                                 start;
    logic [rwam_pkg::CFG_IDX_W-1:0]       idx;
    logic [rwam_pkg::CFG_W-1:0]           data;
    logic                                 known;
    logic [rwam_pkg::CFG_W-1:0]           pos;
  } dir_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [rwam_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                 in_series_start = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [rwam_pkg::CFG_W-1:0]           out_position;
  logic                                 cfg_we = 1'b0;
  logic [rwam_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [rwam_pkg::CFG_W-1:0]           cfg_wdata = '0;

  rolling_window_argmin_argmax DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_series_start(in_series_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position   (out_position),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Window model: register copies, sample history and series count.
  logic [rwam_pkg::CFG_W-1:0]           win_len_q = rwam_pkg::WIN_RESET;
  logic                                 partial_q = 1'b1;
  logic                                 fmax_q    = 1'b0;
  logic signed [rwam_pkg::SAMPLE_W-1:0] hist [rwam_pkg::MAX_WINDOW];
  logic [rwam_pkg::ADDR_W-1:0]          hist_wr = '0;
  int unsigned                          hist_count = 0;

  logic [rwam_pkg::CFG_W-1:0] argpos_q [$];
  logic [rwam_pkg::CFG_W-1:0] want_pos;
  int                         mismatch_cnt = 0;
  int                         cycle_cnt = 0;
  int                         in_idle_pct = 0;
  int                         out_idle_pct = 0;
  bit                         hold_req = 1'b0;
  int                         hold_left = 0;
  int                         out_gap;

  run_kind_t                            run_kind = RUN_RANDOM;
  int                                   run_left = 0;
  logic signed [rwam_pkg::SAMPLE_W-1:0] run_val = '0;

  dir_row_t dir_tab [DIR_ROWS];

  function automatic logic outranks(input logic signed [rwam_pkg::SAMPLE_W-1:0] cand,
                                    input logic signed [rwam_pkg::SAMPLE_W-1:0] best);
    return fmax_q ? (cand > best) : (cand < best);
  endfunction

  // Position of the extreme over the preceding window; advances the history.
  function automatic logic [rwam_pkg::CFG_W-1:0] predict_position(
      input logic signed [rwam_pkg::SAMPLE_W-1:0] smp, input logic start);
    int unsigned                          w, n, oldest, k;
    logic                                 warm;
    logic signed [rwam_pkg::SAMPLE_W-1:0] best;
    logic [rwam_pkg::CFG_W-1:0]           pos;
    w = win_len_q;
    if (w < 1) w = 1;
    if (w > rwam_pkg::MAX_WINDOW) w = rwam_pkg::MAX_WINDOW;
    if (start) hist_count = 0;
    warm = hist_count < w;
    n = warm ? hist_count : w;
    oldest = (hist_wr + rwam_pkg::MAX_WINDOW - n) % rwam_pkg::MAX_WINDOW;
    pos = '0;
    best = '0;
    if (!warm || partial_q) begin
      for (k = 0; k < n; k++) begin
        if (k == 0 || outranks(hist[(oldest + k) % rwam_pkg::MAX_WINDOW], best)) begin
          best = hist[(oldest + k) % rwam_pkg::MAX_WINDOW];
          pos = rwam_pkg::CFG_W'(k + 1);
        end
      end
      // warm-up counts the current sample as the newest position
      if (warm && (n == 0 || outranks(smp, best))) pos = rwam_pkg::CFG_W'(n + 1);
    end
    hist[hist_wr] = smp;
    hist_wr = hist_wr + 1'b1;
    if (hist_count < rwam_pkg::MAX_WINDOW) hist_count++;
    return pos;
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Runs of one flavor: plain random, near ties, extremes, monotonic (forces rescans).
  function automatic logic signed [rwam_pkg::SAMPLE_W-1:0] next_sample();
    if (run_left == 0) begin
      run_kind = run_kind_t'($urandom_range(4));
      run_left = $urandom_range(3, 40);
      run_val = $urandom;
    end
    run_left--;
    case (run_kind)
      RUN_TIES: return int'($urandom_range(6)) - 3;
      RUN_EXTREMES: begin
        case ($urandom_range(3))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      RUN_RISING: begin
        run_val = run_val + $urandom_range(1, 5000);
        return run_val;
      end
      RUN_FALLING: begin
        run_val = run_val - $urandom_range(1, 5000);
        return run_val;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic put_item(input logic signed [rwam_pkg::SAMPLE_W-1:0] smp, input logic start,
                          input logic known, input logic [rwam_pkg::CFG_W-1:0] known_pos);
    int                         gap;
    logic [rwam_pkg::CFG_W-1:0] pred;
    gap = pick_gap(in_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= smp;
    in_series_start <= start;
    do @(posedge clk); while (in_stall);
    pred = predict_position(smp, start);
    argpos_q.push_back(known ? known_pos : pred);
  endtask

  // Drop valid and wait until every position has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (argpos_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rwam_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rwam_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      rwam_pkg::REG_WINDOW_LENGTH: win_len_q = data;
      rwam_pkg::REG_PARTIAL_MODE:  partial_q = data[0];
      rwam_pkg::REG_FIND_MAX:      fmax_q = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_gap = pick_gap(out_idle_pct);
      out_stall <= (out_gap > 0);
      if (out_gap > 0) hold_left = out_gap - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d positions outstanding", cycle_cnt,
               argpos_q.size());
      $display("Regression FAIL");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (argpos_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected transaction: position %0d", out_position);
      end else begin
        want_pos = argpos_q.pop_front();
        if (out_position !== want_pos) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("position mismatch: expected %0d, got %0d", want_pos, out_position);
        end
      end
    end
  end

  initial begin
    dir_tab = '{
      '{ROW_ITEM, S_MAX,          1'b1, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b1, 6'd1},
      '{ROW_ITEM, S_MIN,          1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd0,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, -32'sd1,        1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, S_MIN,          1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_FIND_MAX,      6'd1,  1'b0, 6'd0},
      '{ROW_ITEM, S_MAX,          1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, S_MAX,          1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd5,         1'b1, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b1, 6'd1},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_PARTIAL_MODE,  6'h3E, 1'b0, 6'd0},
      '{ROW_ITEM, 32'sd3,         1'b1, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b1, 6'd0},
      '{ROW_ITEM, 32'sd4,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b1, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd9,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, -32'sd9,        1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd63, 1'b0, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, REG_UNUSED,                  6'd1,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd1,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b1, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_PARTIAL_MODE,  6'd1,  1'b0, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd2,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd10,        1'b1, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b1, 6'd1},
      '{ROW_ITEM, 32'sd20,        1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd30,        1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd40,        1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_FIND_MAX,      6'd0,  1'b0, 6'd0},
      '{ROW_CFG,  32'sd0,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd33, 1'b0, 6'd0},
      '{ROW_ITEM, S_MAX,          1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sd0,         1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, S_MIN,          1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0},
      '{ROW_ITEM, 32'sh8000_0001, 1'b0, rwam_pkg::REG_WINDOW_LENGTH, 6'd0,  1'b0, 6'd0}
    };
  end

  initial begin
    logic [rwam_pkg::CFG_W-1:0] phase_win [PHASES];
    logic [rwam_pkg::CFG_W-1:0] win;
    logic                       part;
    phase_win = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd5, 6'd33, 6'd2, 6'd16};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[r].idx, dir_tab[r].data);
      end else begin
        put_item(dir_tab[r].smp, dir_tab[r].start, dir_tab[r].known, dir_tab[r].pos);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      win = (phase == PHASES - 1) ? rwam_pkg::CFG_W'($urandom_range(63)) : phase_win[phase];
      part = (phase == 3) ? 1'($urandom_range(1)) : ~phase[0];
      write_reg(rwam_pkg::REG_WINDOW_LENGTH, win);
      write_reg(rwam_pkg::REG_PARTIAL_MODE, {5'($urandom_range(31)), part});
      write_reg(rwam_pkg::REG_FIND_MAX, {5'($urandom_range(31)), phase[1]});
      write_reg(REG_UNUSED, rwam_pkg::CFG_W'($urandom_range(63)));
      if (phase == 0) begin
        // keep offering while the receiver holds off, so the block backs up
        in_idle_pct = 0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 60 == 59) begin
          in_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
          out_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
        end
        put_item(next_sample(), $urandom_range(49) == 0, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rwam_pkg.sv
rtl/core/rwam_ctrl.sv
rtl/core/rwam_dp.sv
rtl/core/rolling_window_argmin_argmax.sv
bench/tb_rolling_window_argmin_argmax.sv
